FILE: design/pmftl_pkg.sv
// Shared types and codes of the page-mapped flash translation controller.
// No dependencies; imported by the controller top level.
package pmftl_pkg;

  localparam int ERASE_W = 16;
  localparam int PAGE_OUT_W = 10;

  typedef enum logic [2:0] {
    CMD_READ     = 3'd0,
    CMD_MERGE    = 3'd1,
    CMD_PROGRAM  = 3'd2,
    CMD_COPY     = 3'd3,
    CMD_ERASE    = 3'd4,
    CMD_UNMAPPED = 3'd5,
    CMD_RANGE    = 3'd6,
    CMD_NOSPACE  = 3'd7
  } cmd_e;

  localparam logic FUNC_READ = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    cmd_e                  cmd;
    logic [PAGE_OUT_W-1:0] phys;
    logic [PAGE_OUT_W-1:0] dest;
    logic [2:0]            fs;
    logic [3:0]            sc;
    logic                  last;
  } pmftl_out_t;

endpackage

FILE: design/pmftl_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies; used for every table of the controller.
module pmftl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/page_mapped_ftl_controller.sv
// Page-mapped flash translation controller with greedy garbage collection.
// Depends on pmftl_pkg and pmftl_ram.
//
// Requests arrive on the s_axis channel: tuser carries the read/write kind,
// tdata the logical page and sector range. Commands for the flash back end
// leave on the m_axis channel, one per beat, tlast marking the final command
// of a request. gc_threshold is written through cfg_wr_en_i/cfg_wr_data_i;
// the user must do so only while the block is idle, which it does not enforce.
// One request is processed at a time. When a write must open a new block,
// the free-block search walks the block counter RAM one entry per cycle
// over its single read port. A collection adds two such scans, a read and
// an evaluation step per page of the victim block, and a pass that clears
// its invalid bits one page at a time.
// After reset the tables are cleared, during which no request is taken.
// The output register holds a command while the receiver stalls; the
// controller stops at its next command until the register frees up, and a
// new request is taken while the last command of the previous one waits.
module page_mapped_ftl_controller import pmftl_pkg::*; #(
  parameter int BLOCK_COUNT      = 64,
  parameter int PAGES_PER_BLOCK  = 16,
  parameter int USER_BLOCKS      = 56,
  parameter int SECTORS_PER_PAGE = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [9:0] logical_page, [12:10] first_sector, [16:13] sector_count
  input  logic [23:0] s_axis_tdata_i,
  // [0] func
  input  logic [0:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [9:0] phys_page, [19:10] dest_page, [22:20] first_sector_res,
  // [26:23] sector_count_res
  output logic [31:0] m_axis_tdata_o,
  // [2:0] command
  output logic [2:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  input  logic        cfg_wr_en_i,
  input  logic [9:0]  cfg_wr_data_i
);

  localparam int PHYS    = BLOCK_COUNT * PAGES_PER_BLOCK;
  localparam int LOGICAL = USER_BLOCKS * PAGES_PER_BLOCK;
  localparam int PA_W    = $clog2(PHYS);
  localparam int LA_W    = $clog2(LOGICAL);
  localparam int BA_W    = $clog2(BLOCK_COUNT);
  localparam int WB_W    = $clog2(BLOCK_COUNT + 1);
  localparam int PI_W    = $clog2(PAGES_PER_BLOCK);
  localparam int CNT_W   = $clog2(PAGES_PER_BLOCK + 1);
  localparam int PP_W    = $clog2(PHYS + 1);
  localparam int BW      = 2 * CNT_W + ERASE_W;
  localparam int L2P_W   = 1 + BA_W + PI_W;
  localparam logic [9:0] THR_RESET = 10'((BLOCK_COUNT - 4) * PAGES_PER_BLOCK - 1);

  localparam logic [4:0] S_CLEAR    = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_DECODE   = 5'd2;
  localparam logic [4:0] S_RD_OUT   = 5'd3;
  localparam logic [4:0] S_SCAN     = 5'd4;
  localparam logic [4:0] S_SCAN_END = 5'd5;
  localparam logic [4:0] S_W_L2P    = 5'd6;
  localparam logic [4:0] S_W_INV    = 5'd7;
  localparam logic [4:0] S_W_INVCNT = 5'd8;
  localparam logic [4:0] S_MERGE    = 5'd9;
  localparam logic [4:0] S_PROG     = 5'd10;
  localparam logic [4:0] S_PROG_BLK = 5'd11;
  localparam logic [4:0] S_PROG_OUT = 5'd12;
  localparam logic [4:0] S_CP_RD    = 5'd13;
  localparam logic [4:0] S_CP_EV    = 5'd14;
  localparam logic [4:0] S_ER_CLR   = 5'd15;
  localparam logic [4:0] S_ER_BLK   = 5'd16;
  localparam logic [4:0] S_ER_VIC   = 5'd17;
  localparam logic [4:0] S_ER_OUT   = 5'd18;

  localparam logic SCAN_FREE = 1'b0;
  localparam logic SCAN_VICTIM = 1'b1;

  function automatic logic [PA_W-1:0] flat(input logic [BA_W-1:0] b,
                                           input logic [PI_W-1:0] i);
    flat = PA_W'(b * PAGES_PER_BLOCK + i);
  endfunction

  // Control and request registers.
  logic [4:0]         state_q, state_d;
  logic [PA_W-1:0]    clr_q, clr_d;
  logic [9:0]         thr_q;
  logic               func_q, func_d;
  logic [9:0]         lp_q, lp_d;
  logic [2:0]         fs_q, fs_d;
  logic [3:0]         sc_q, sc_d;
  logic               gc_q, gc_d;
  logic [WB_W-1:0]    wp_blk_q, wp_blk_d;
  logic [PI_W-1:0]    wp_idx_q, wp_idx_d;
  logic [PP_W-1:0]    pp_q, pp_d;
  logic [BA_W-1:0]    old_blk_q, old_blk_d;
  logic [PI_W-1:0]    old_idx_q, old_idx_d;
  logic [BA_W-1:0]    np_blk_q, np_blk_d;
  // Scan of the block counters.
  logic               scan_kind_q, scan_kind_d;
  logic [WB_W-1:0]    scan_idx_q, scan_idx_d;
  logic               pend_q, pend_d;
  logic [BA_W-1:0]    pend_idx_q, pend_idx_d;
  logic               found_q, found_d;
  logic [BA_W-1:0]    best_blk_q, best_blk_d;
  logic [CNT_W-1:0]   best_inv_q, best_inv_d;
  logic [CNT_W-1:0]   best_fill_q, best_fill_d;
  logic [ERASE_W-1:0] best_erase_q, best_erase_d;
  // Collection.
  logic [BA_W-1:0]    v_blk_q, v_blk_d;
  logic [CNT_W-1:0]   v_fill_q, v_fill_d;
  logic [ERASE_W-1:0] v_erase_q, v_erase_d;
  logic [BA_W-1:0]    t_blk_q, t_blk_d;
  logic [CNT_W-1:0]   t_inv_q, t_inv_d;
  logic [ERASE_W-1:0] t_erase_q, t_erase_d;
  logic [CNT_W-1:0]   tp_q, tp_d;
  logic [CNT_W-1:0]   cp_q, cp_d;
  // Read address registers of the RAMs.
  logic [PA_W-1:0]    pg_raddr_q, pg_raddr_d;
  logic [BA_W-1:0]    blk_raddr_q, blk_raddr_d;
  // Output register.
  logic               out_valid_q;
  pmftl_out_t         out_q;
  logic               emit;
  pmftl_out_t         emit_item;
  logic               out_free;

  // RAM ports.
  logic               l2p_we;
  logic [LA_W-1:0]    l2p_waddr;
  logic [L2P_W-1:0]   l2p_wdata, l2p_rdata;
  logic               p2l_we;
  logic [PA_W-1:0]    p2l_waddr;
  logic [LA_W-1:0]    p2l_wdata, p2l_rdata;
  logic               inv_we;
  logic [PA_W-1:0]    inv_waddr;
  logic [0:0]         inv_wdata, inv_rdata;
  logic               blk_we;
  logic [BA_W-1:0]    blk_waddr;
  logic [BW-1:0]      blk_wdata, blk_rdata;

  logic [CNT_W-1:0]   rd_inv, rd_fill;
  logic [ERASE_W-1:0] rd_erase;
  logic               rd_mapped;
  logic [BA_W-1:0]    rd_blk;
  logic [PI_W-1:0]    rd_idx;
  logic               bad_req, need_blk, take, gc_start;
  logic [CNT_W-1:0]   v_lim;

  pmftl_ram #(.WIDTH(L2P_W), .DEPTH(LOGICAL)) u_l2p_ram (
    .clk_i, .we_i(l2p_we), .waddr_i(l2p_waddr), .wdata_i(l2p_wdata),
    .raddr_i(LA_W'(lp_q)), .rdata_o(l2p_rdata)
  );

  pmftl_ram #(.WIDTH(LA_W), .DEPTH(PHYS)) u_p2l_ram (
    .clk_i, .we_i(p2l_we), .waddr_i(p2l_waddr), .wdata_i(p2l_wdata),
    .raddr_i(pg_raddr_d), .rdata_o(p2l_rdata)
  );

  pmftl_ram #(.WIDTH(1), .DEPTH(PHYS)) u_inv_ram (
    .clk_i, .we_i(inv_we), .waddr_i(inv_waddr), .wdata_i(inv_wdata),
    .raddr_i(pg_raddr_d), .rdata_o(inv_rdata)
  );

  pmftl_ram #(.WIDTH(BW), .DEPTH(BLOCK_COUNT)) u_blk_ram (
    .clk_i, .we_i(blk_we), .waddr_i(blk_waddr), .wdata_i(blk_wdata),
    .raddr_i(blk_raddr_d), .rdata_o(blk_rdata)
  );

  assign rd_erase  = blk_rdata[ERASE_W-1:0];
  assign rd_fill   = blk_rdata[ERASE_W +: CNT_W];
  assign rd_inv    = blk_rdata[ERASE_W + CNT_W +: CNT_W];
  assign rd_mapped = l2p_rdata[L2P_W-1];
  assign rd_blk    = l2p_rdata[PI_W +: BA_W];
  assign rd_idx    = l2p_rdata[PI_W-1:0];

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign bad_req  = (32'(lp_q) >= 32'(LOGICAL)) || (sc_q == 4'd0)
                  || ((8'(fs_q) + 8'(sc_q)) > 8'(SECTORS_PER_PAGE));
  assign need_blk = (wp_idx_q == '0) || (32'(wp_blk_q) >= 32'(BLOCK_COUNT));
  assign gc_start = 32'(pp_q) > 32'(thr_q);
  assign v_lim    = (32'(v_fill_q) > 32'(PAGES_PER_BLOCK)) ? CNT_W'(PAGES_PER_BLOCK)
                                                          : v_fill_q;

  always_comb begin
    if (scan_kind_q == SCAN_FREE) begin
      take = (rd_fill == '0) && (!found_q || rd_erase < best_erase_q);
    end else begin
      take = !found_q || rd_inv > best_inv_q;
    end
  end

  always_comb begin
    state_d = state_q;       clr_d = clr_q;
    func_d = func_q;         lp_d = lp_q;        fs_d = fs_q;       sc_d = sc_q;
    gc_d = gc_q;             wp_blk_d = wp_blk_q; wp_idx_d = wp_idx_q; pp_d = pp_q;
    old_blk_d = old_blk_q;   old_idx_d = old_idx_q; np_blk_d = np_blk_q;
    scan_kind_d = scan_kind_q; scan_idx_d = scan_idx_q;
    pend_d = pend_q;         pend_idx_d = pend_idx_q;
    found_d = found_q;       best_blk_d = best_blk_q; best_inv_d = best_inv_q;
    best_fill_d = best_fill_q; best_erase_d = best_erase_q;
    v_blk_d = v_blk_q;       v_fill_d = v_fill_q; v_erase_d = v_erase_q;
    t_blk_d = t_blk_q;       t_inv_d = t_inv_q;   t_erase_d = t_erase_q;
    tp_d = tp_q;             cp_d = cp_q;
    pg_raddr_d = pg_raddr_q; blk_raddr_d = blk_raddr_q;
    emit = 1'b0;             emit_item = '0;
    l2p_we = 1'b0; l2p_waddr = '0; l2p_wdata = '0;
    p2l_we = 1'b0; p2l_waddr = '0; p2l_wdata = '0;
    inv_we = 1'b0; inv_waddr = '0; inv_wdata = '0;
    blk_we = 1'b0; blk_waddr = '0; blk_wdata = '0;
    s_axis_tready_o = 1'b0;

    case (state_q)
      S_CLEAR: begin
        l2p_we    = 32'(clr_q) < 32'(LOGICAL);
        l2p_waddr = clr_q[LA_W-1:0];
        inv_we    = 1'b1;
        inv_waddr = clr_q;
        blk_we    = 32'(clr_q) < 32'(BLOCK_COUNT);
        blk_waddr = clr_q[BA_W-1:0];
        clr_d     = clr_q + 1'b1;
        if (clr_q == PA_W'(PHYS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          func_d  = s_axis_tuser_i[0];
          lp_d    = s_axis_tdata_i[9:0];
          fs_d    = s_axis_tdata_i[12:10];
          sc_d    = s_axis_tdata_i[16:13];
          gc_d    = 1'b0;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        // The mapping table is read at the request's page in this cycle.
        if (bad_req) begin
          if (out_free) begin
            emit = 1'b1;
            emit_item.cmd  = CMD_RANGE;
            emit_item.last = 1'b1;
            state_d = S_IDLE;
          end
        end else if (func_q == FUNC_READ) begin
          state_d = S_RD_OUT;
        end else if (need_blk) begin
          scan_kind_d = SCAN_FREE;
          scan_idx_d  = '0;
          pend_d      = 1'b0;
          found_d     = 1'b0;
          state_d     = S_SCAN;
        end else begin
          state_d = S_W_L2P;
        end
      end
      S_RD_OUT: begin
        if (out_free) begin
          emit = 1'b1;
          emit_item.last = 1'b1;
          if (rd_mapped) begin
            emit_item.cmd  = CMD_READ;
            emit_item.phys = PAGE_OUT_W'(flat(rd_blk, rd_idx));
            emit_item.fs   = fs_q;
            emit_item.sc   = sc_q;
          end else begin
            emit_item.cmd = CMD_UNMAPPED;
          end
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (pend_q && take) begin
          found_d      = 1'b1;
          best_blk_d   = pend_idx_q;
          best_inv_d   = rd_inv;
          best_fill_d  = rd_fill;
          best_erase_d = rd_erase;
        end
        if (32'(scan_idx_q) < 32'(BLOCK_COUNT)) begin
          blk_raddr_d = scan_idx_q[BA_W-1:0];
          pend_d      = 1'b1;
          pend_idx_d  = scan_idx_q[BA_W-1:0];
          scan_idx_d  = scan_idx_q + 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        if (scan_kind_q == SCAN_VICTIM) begin
          if (!found_q || best_inv_q == '0) begin
            if (out_free) begin
              emit = 1'b1;
              emit_item.cmd  = CMD_NOSPACE;
              emit_item.last = 1'b1;
              state_d = S_IDLE;
            end
          end else begin
            v_blk_d     = best_blk_q;
            v_fill_d    = best_fill_q;
            v_erase_d   = best_erase_q;
            scan_kind_d = SCAN_FREE;
            scan_idx_d  = '0;
            pend_d      = 1'b0;
            found_d     = 1'b0;
            state_d     = S_SCAN;
          end
        end else if (!found_q) begin
          if (out_free) begin
            emit = 1'b1;
            emit_item.cmd  = CMD_NOSPACE;
            emit_item.last = 1'b1;
            state_d = S_IDLE;
          end
        end else if (gc_q) begin
          t_blk_d   = best_blk_q;
          t_inv_d   = best_inv_q;
          t_erase_d = best_erase_q;
          tp_d      = '0;
          cp_d      = '0;
          state_d   = S_CP_RD;
        end else begin
          wp_blk_d = WB_W'(best_blk_q);
          wp_idx_d = '0;
          state_d  = S_W_L2P;
        end
      end
      S_W_L2P: begin
        if (rd_mapped) begin
          old_blk_d  = rd_blk;
          old_idx_d  = rd_idx;
          pg_raddr_d = flat(rd_blk, rd_idx);
          state_d    = S_W_INV;
        end else begin
          state_d = S_PROG;
        end
      end
      S_W_INV: begin
        if (inv_rdata == 1'b0) begin
          inv_we      = 1'b1;
          inv_waddr   = flat(old_blk_q, old_idx_q);
          inv_wdata   = 1'b1;
          blk_raddr_d = old_blk_q;
          state_d     = S_W_INVCNT;
        end else begin
          state_d = S_MERGE;
        end
      end
      S_W_INVCNT: begin
        blk_we    = 1'b1;
        blk_waddr = old_blk_q;
        blk_wdata = {rd_inv + 1'b1, rd_fill, rd_erase};
        state_d   = S_MERGE;
      end
      S_MERGE: begin
        if (out_free) begin
          emit = 1'b1;
          emit_item.cmd  = CMD_MERGE;
          emit_item.phys = PAGE_OUT_W'(flat(old_blk_q, old_idx_q));
          emit_item.fs   = fs_q;
          emit_item.sc   = sc_q;
          state_d = S_PROG;
        end
      end
      S_PROG: begin
        l2p_we    = 1'b1;
        l2p_waddr = LA_W'(lp_q);
        l2p_wdata = {1'b1, wp_blk_q[BA_W-1:0], wp_idx_q};
        p2l_we    = 1'b1;
        p2l_waddr = flat(wp_blk_q[BA_W-1:0], wp_idx_q);
        p2l_wdata = LA_W'(lp_q);
        old_idx_d = wp_idx_q;
        np_blk_d  = wp_blk_q[BA_W-1:0];
        pp_d      = pp_q + 1'b1;
        if (wp_idx_q == PI_W'(PAGES_PER_BLOCK - 1)) begin
          wp_blk_d = wp_blk_q + 1'b1;
          wp_idx_d = '0;
        end else begin
          wp_idx_d = wp_idx_q + 1'b1;
        end
        blk_raddr_d = wp_blk_q[BA_W-1:0];
        state_d     = S_PROG_BLK;
      end
      S_PROG_BLK: begin
        blk_we    = 1'b1;
        blk_waddr = np_blk_q;
        blk_wdata = {rd_inv, rd_fill + 1'b1, rd_erase};
        state_d   = S_PROG_OUT;
      end
      S_PROG_OUT: begin
        if (out_free) begin
          emit = 1'b1;
          emit_item.cmd  = CMD_PROGRAM;
          emit_item.phys = PAGE_OUT_W'(flat(np_blk_q, old_idx_q));
          emit_item.fs   = fs_q;
          emit_item.sc   = sc_q;
          emit_item.last = !gc_start;
          if (gc_start) begin
            gc_d        = 1'b1;
            scan_kind_d = SCAN_VICTIM;
            scan_idx_d  = '0;
            pend_d      = 1'b0;
            found_d     = 1'b0;
            state_d     = S_SCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_CP_RD: begin
        if (cp_q == v_lim) begin
          cp_d    = '0;
          state_d = S_ER_CLR;
        end else begin
          pg_raddr_d = flat(v_blk_q, cp_q[PI_W-1:0]);
          state_d    = S_CP_EV;
        end
      end
      S_CP_EV: begin
        if (inv_rdata == 1'b1) begin
          cp_d    = cp_q + 1'b1;
          state_d = S_CP_RD;
        end else if (out_free) begin
          // A valid page moves to the next page of the target block.
          l2p_we    = 32'(p2l_rdata) < 32'(LOGICAL);
          l2p_waddr = p2l_rdata;
          l2p_wdata = {1'b1, t_blk_q, tp_q[PI_W-1:0]};
          p2l_we    = 1'b1;
          p2l_waddr = flat(t_blk_q, tp_q[PI_W-1:0]);
          p2l_wdata = p2l_rdata;
          pp_d      = pp_q + 1'b1;
          emit = 1'b1;
          emit_item.cmd  = CMD_COPY;
          emit_item.phys = PAGE_OUT_W'(flat(v_blk_q, cp_q[PI_W-1:0]));
          emit_item.dest = PAGE_OUT_W'(flat(t_blk_q, tp_q[PI_W-1:0]));
          tp_d    = tp_q + 1'b1;
          cp_d    = cp_q + 1'b1;
          state_d = S_CP_RD;
        end
      end
      S_ER_CLR: begin
        inv_we    = 1'b1;
        inv_waddr = flat(v_blk_q, cp_q[PI_W-1:0]);
        cp_d      = cp_q + 1'b1;
        if (cp_q == CNT_W'(PAGES_PER_BLOCK - 1)) begin
          state_d = S_ER_BLK;
        end
      end
      S_ER_BLK: begin
        blk_we    = 1'b1;
        blk_waddr = t_blk_q;
        blk_wdata = {t_inv_q, tp_q, t_erase_q};
        if (tp_q == CNT_W'(PAGES_PER_BLOCK)) begin
          wp_blk_d = WB_W'(t_blk_q) + 1'b1;
          wp_idx_d = '0;
        end else begin
          wp_blk_d = WB_W'(t_blk_q);
          wp_idx_d = tp_q[PI_W-1:0];
        end
        state_d = S_ER_VIC;
      end
      S_ER_VIC: begin
        blk_we    = 1'b1;
        blk_waddr = v_blk_q;
        blk_wdata = {{CNT_W{1'b0}}, {CNT_W{1'b0}},
                     (v_erase_q == '1) ? v_erase_q : v_erase_q + 1'b1};
        pp_d      = (32'(pp_q) > 32'(v_fill_q)) ? pp_q - PP_W'(v_fill_q) : '0;
        state_d   = S_ER_OUT;
      end
      S_ER_OUT: begin
        if (out_free) begin
          emit = 1'b1;
          emit_item.cmd  = CMD_ERASE;
          emit_item.phys = PAGE_OUT_W'(flat(v_blk_q, '0));
          emit_item.last = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      thr_q        <= THR_RESET;
      func_q       <= 1'b0;
      lp_q         <= '0;
      fs_q         <= '0;
      sc_q         <= '0;
      gc_q         <= 1'b0;
      wp_blk_q     <= '0;
      wp_idx_q     <= '0;
      pp_q         <= '0;
      old_blk_q    <= '0;
      old_idx_q    <= '0;
      np_blk_q     <= '0;
      scan_kind_q  <= SCAN_FREE;
      scan_idx_q   <= '0;
      pend_q       <= 1'b0;
      pend_idx_q   <= '0;
      found_q      <= 1'b0;
      best_blk_q   <= '0;
      best_inv_q   <= '0;
      best_fill_q  <= '0;
      best_erase_q <= '0;
      v_blk_q      <= '0;
      v_fill_q     <= '0;
      v_erase_q    <= '0;
      t_blk_q      <= '0;
      t_inv_q      <= '0;
      t_erase_q    <= '0;
      tp_q         <= '0;
      cp_q         <= '0;
      pg_raddr_q   <= '0;
      blk_raddr_q  <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      if (cfg_wr_en_i) begin
        thr_q <= cfg_wr_data_i;
      end
      func_q       <= func_d;
      lp_q         <= lp_d;
      fs_q         <= fs_d;
      sc_q         <= sc_d;
      gc_q         <= gc_d;
      wp_blk_q     <= wp_blk_d;
      wp_idx_q     <= wp_idx_d;
      pp_q         <= pp_d;
      old_blk_q    <= old_blk_d;
      old_idx_q    <= old_idx_d;
      np_blk_q     <= np_blk_d;
      scan_kind_q  <= scan_kind_d;
      scan_idx_q   <= scan_idx_d;
      pend_q       <= pend_d;
      pend_idx_q   <= pend_idx_d;
      found_q      <= found_d;
      best_blk_q   <= best_blk_d;
      best_inv_q   <= best_inv_d;
      best_fill_q  <= best_fill_d;
      best_erase_q <= best_erase_d;
      v_blk_q      <= v_blk_d;
      v_fill_q     <= v_fill_d;
      v_erase_q    <= v_erase_d;
      t_blk_q      <= t_blk_d;
      t_inv_q      <= t_inv_d;
      t_erase_q    <= t_erase_d;
      tp_q         <= tp_d;
      cp_q         <= cp_d;
      pg_raddr_q   <= pg_raddr_d;
      blk_raddr_q  <= blk_raddr_d;
      if (emit) begin
        out_valid_q <= 1'b1;
        out_q       <= emit_item;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_q.sc, out_q.fs, out_q.dest, out_q.phys};
  assign m_axis_tuser_o  = out_q.cmd;
  assign m_axis_tlast_o  = out_q.last;

  // A new command never overwrites one the receiver has not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni) emit |-> out_free)
    else $error("command issued into a full output register");

  // Erase commands come only from a collection, as its final command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_item.cmd == CMD_ERASE) |-> (gc_q && emit_item.last))
    else $error("erase issued outside a collection");

  // Pages copied never outnumber victim pages examined.
  assert property (@(posedge clk_i) disable iff (!rst_ni) tp_q <= cp_q || state_q == S_ER_CLR)
    else $error("copy destination ran ahead of the victim walk");

  // The write pointer index stays inside a block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wp_idx_q) < 32'(PAGES_PER_BLOCK))
    else $error("write pointer index left the block");

endmodule

FILE: tb/page_mapped_ftl_controller_tb.sv
// Self-checking testbench of the page-mapped flash translation controller.
// Depends on pmftl_pkg and the controller RTL; a built-in mapping predictor
// checks every command against a directed table and random request streams.
module page_mapped_ftl_controller_tb;
  import pmftl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = 64;
  localparam int PPB = 16;
  localparam int NLOG = 56 * PPB;
  localparam int NPHYS = NBLK * PPB;
  localparam int SPP = 8;
  localparam int SETTLE = 400;
  localparam int LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic [0:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        cfg_wr_en_i = 1'b0;
  logic [9:0]  cfg_wr_data_i = '0;

  page_mapped_ftl_controller dut (.*);

  // Predictor state of the mapping tables.
  logic [9:0]  thr_q;
  bit          map_valid[NLOG];
  int          lp_to_pp[NLOG];
  int          pp_to_lp[NPHYS];
  bit          stale_page[NPHYS];
  int          blk_stale[NBLK];
  int          blk_fill[NBLK];
  int          blk_erases[NBLK];
  int          wr_ptr;
  int          pages_used;

  pmftl_out_t  cmd_q[$];
  pmftl_out_t  item_cmds[$];
  int          cycles = 0;
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  initial begin
    forever begin
      #10 clk_i = ~clk_i;
      if (clk_i) begin
        cycles++;
        if (cycles > LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  function automatic void emit(cmd_e c, int phys, int dest, int fs, int sc);
    pmftl_out_t r;
    r.cmd = c;
    r.phys = phys[9:0];
    r.dest = dest[9:0];
    r.fs = fs[2:0];
    r.sc = sc[3:0];
    r.last = 1'b0;
    item_cmds.push_back(r);
  endfunction

  function automatic bit find_free_blk(output int blk);
    bit found = 0;
    int best = 0;
    blk = 0;
    for (int i = 0; i < NBLK; i++) begin
      if (blk_fill[i] == 0 && (!found || blk_erases[i] < best)) begin
        found = 1;
        best = blk_erases[i];
        blk = i;
      end
    end
    return found;
  endfunction

  function automatic void collect_garbage();
    int victim = 0;
    int tgt;
    int tp;
    int fill;
    int src;
    for (int i = 1; i < NBLK; i++)
      if (blk_stale[i] > blk_stale[victim]) victim = i;
    if (blk_stale[victim] == 0 || !find_free_blk(tgt)) begin
      emit(CMD_NOSPACE, 0, 0, 0, 0);
      return;
    end
    tp = tgt * PPB;
    fill = (blk_fill[victim] > PPB) ? PPB : blk_fill[victim];
    for (int i = 0; i < fill; i++) begin
      src = victim * PPB + i;
      if (!stale_page[src]) begin
        if (pp_to_lp[src] < NLOG) begin
          lp_to_pp[pp_to_lp[src]] = tp;
          map_valid[pp_to_lp[src]] = 1;
        end
        pp_to_lp[tp] = pp_to_lp[src];
        blk_fill[tgt]++;
        pages_used++;
        emit(CMD_COPY, src, tp, 0, 0);
        tp++;
      end
    end
    emit(CMD_ERASE, victim * PPB, 0, 0, 0);
    if (blk_erases[victim] < 'hFFFF) blk_erases[victim]++;
    pages_used = (pages_used > blk_fill[victim]) ? pages_used - blk_fill[victim] : 0;
    blk_fill[victim] = 0;
    blk_stale[victim] = 0;
    for (int i = 0; i < PPB; i++) stale_page[victim * PPB + i] = 0;
    wr_ptr = tp;
  endfunction

  // Works out the commands of one accepted request into item_cmds.
  function automatic void translate_request(logic func, int lp, int fs, int sc);
    int blk = 0;
    int np;
    int old;
    bit open_blk;
    item_cmds.delete();
    if (lp >= NLOG || sc == 0 || fs + sc > SPP) begin
      emit(CMD_RANGE, 0, 0, 0, 0);
    end else if (func == FUNC_READ) begin
      if (map_valid[lp]) emit(CMD_READ, lp_to_pp[lp], 0, fs, sc);
      else emit(CMD_UNMAPPED, 0, 0, 0, 0);
    end else begin
      open_blk = (wr_ptr % PPB) == 0 || wr_ptr >= NPHYS;
      if (open_blk && !find_free_blk(blk)) begin
        emit(CMD_NOSPACE, 0, 0, 0, 0);
      end else begin
        if (open_blk) wr_ptr = blk * PPB;
        if (map_valid[lp]) begin
          old = lp_to_pp[lp];
          if (old < NPHYS && !stale_page[old]) begin
            stale_page[old] = 1;
            blk_stale[old / PPB]++;
          end
          emit(CMD_MERGE, old, 0, fs, sc);
        end
        np = wr_ptr;
        lp_to_pp[lp] = np;
        map_valid[lp] = 1;
        pp_to_lp[np] = lp;
        wr_ptr = np + 1;
        pages_used++;
        blk_fill[np / PPB]++;
        emit(CMD_PROGRAM, np, 0, fs, sc);
        if (pages_used > thr_q) collect_garbage();
      end
    end
    item_cmds[item_cmds.size() - 1].last = 1'b1;
  endfunction

  // Sends one request and queues its expected commands once accepted.
  // A typed code other than CMD_READ replaces the prediction by one command.
  task automatic send_request(logic func, int lp, int fs, int sc, cmd_e typed);
    pmftl_out_t r;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i = func;
    s_axis_tdata_i = {7'd0, sc[3:0], fs[2:0], lp[9:0]};
    do @(posedge clk_i); while (!s_axis_tready_o);
    translate_request(func, lp, fs, sc);
    if (typed != CMD_READ) begin
      r = '0;
      r.cmd = typed;
      r.last = 1'b1;
      item_cmds.delete();
      item_cmds.push_back(r);
    end
    foreach (item_cmds[i]) cmd_q.push_back(item_cmds[i]);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    wait (cmd_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_threshold(int value);
    drain();
    @(negedge clk_i);
    cfg_wr_en_i = 1'b1;
    cfg_wr_data_i = value[9:0];
    @(negedge clk_i);
    cfg_wr_en_i = 1'b0;
    thr_q = value[9:0];
  endtask

  // Output side: random stalls, compare each accepted command.
  initial begin
    pmftl_out_t want;
    pmftl_out_t got;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i = ($urandom_range(0, 99) >= recv_stall_pct);
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.cmd = cmd_e'(m_axis_tuser_o);
        got.phys = m_axis_tdata_o[9:0];
        got.dest = m_axis_tdata_o[19:10];
        got.fs = m_axis_tdata_o[22:20];
        got.sc = m_axis_tdata_o[26:23];
        got.last = m_axis_tlast_o;
        if (cmd_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected command %p", got);
        end else begin
          want = cmd_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  typedef struct {
    logic func;
    int   lp;
    int   fs;
    int   sc;
    cmd_e typed;
  } request_row_t;

  request_row_t directed[] = '{
    '{FUNC_READ,  0,    0, 8, CMD_UNMAPPED},
    '{FUNC_WRITE, 0,    0, 8, CMD_READ},
    '{FUNC_READ,  0,    0, 1, CMD_READ},
    '{FUNC_WRITE, 0,    7, 1, CMD_READ},
    '{FUNC_WRITE, 895,  3, 5, CMD_READ},
    '{FUNC_READ,  895,  0, 8, CMD_READ},
    '{FUNC_WRITE, 512,  4, 4, CMD_READ},
    '{FUNC_WRITE, 512,  2, 3, CMD_READ},
    '{FUNC_READ,  512,  6, 2, CMD_READ},
    '{FUNC_READ,  1,    0, 8, CMD_UNMAPPED},
    '{FUNC_WRITE, 896,  0, 1, CMD_RANGE},
    '{FUNC_READ,  1023, 0, 1, CMD_RANGE},
    '{FUNC_WRITE, 5,    0, 0, CMD_RANGE},
    '{FUNC_READ,  5,    7, 2, CMD_RANGE},
    '{FUNC_WRITE, 5,    0, 15, CMD_RANGE},
    '{FUNC_WRITE, 5,    0, 9, CMD_RANGE},
    '{FUNC_WRITE, 341,  5, 3, CMD_READ},
    '{FUNC_WRITE, 682,  1, 6, CMD_READ},
    '{FUNC_READ,  341,  7, 1, CMD_READ}
  };

  initial begin
    int phase_items[4] = '{25, 25, 20, 20};
    int phase_thr[4] = '{0, 1023, 30, 100};
    int phase_idle[4] = '{74, 0, 33, 0};
    int phase_stall[4] = '{0, 74, 33, 0};
    int roll;
    int fs;
    int lp;
    thr_q = 10'd959;
    wr_ptr = 0;
    pages_used = 0;
    foreach (map_valid[i]) begin
      map_valid[i] = 0;
      lp_to_pp[i] = 0;
    end
    foreach (stale_page[i]) begin
      stale_page[i] = 0;
      pp_to_lp[i] = 0;
    end
    foreach (blk_fill[i]) begin
      blk_fill[i] = 0;
      blk_stale[i] = 0;
      blk_erases[i] = 0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i])
      send_request(directed[i].func, directed[i].lp, directed[i].fs, directed[i].sc,
                   directed[i].typed);

    for (int p = 0; p < 4; p++) begin
      set_threshold(phase_thr[p]);
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      for (int n = 0; n < phase_items[p]; n++) begin
        roll = $urandom_range(0, 99);
        // A small hot set of pages keeps invalid pages around for collection.
        lp = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 47) : $urandom_range(0, NLOG - 1);
        fs = $urandom_range(0, SPP - 1);
        if (roll < 8)
          send_request(1'($urandom_range(0, 1)), $urandom_range(0, 1023), fs,
                       $urandom_range(0, 15), CMD_READ);
        else if (roll < 35)
          send_request(FUNC_READ, lp, fs, $urandom_range(1, SPP - fs), CMD_READ);
        else
          send_request(FUNC_WRITE, lp, fs, $urandom_range(1, SPP - fs), CMD_READ);
      end
    end
    drain();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
